/* rtl/core/rjb_pkg.sv */
package rjb_pkg;

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncPop = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;
  localparam logic [1:0] FuncSpare = 2'd3;

  localparam int unsigned SeqBits = 16;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned HandleField = 16;
  localparam int unsigned FillBits = 9;

  typedef struct packed {
    logic [1:0]             func;
    logic                   header_ok;
    logic [SeqBits-1:0]     seq_number;
    logic [TimeBits-1:0]    rtp_timestamp;
    logic [HandleField-1:0] packet_handle;
    logic [TimeBits-1:0]    ref_timestamp;
  } item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    pop_valid;
    logic [HandleField-1:0]  packet_out;
    logic [TimeBits-1:0]     span_delay;
    logic signed [TimeBits-1:0] ref_delay;
    logic [FillBits-1:0]     fill_level;
    logic                    is_empty;
  } result_t;

endpackage

/* rtl/core/rtp_jitter_reorder_buffer_top.sv */
// channel  | direction | handshake            | payload
// item     | in        | start & !busy        | item_i   (rjb_pkg::item_t)
// result   | out       | valid_o, one cycle   | result_o (rjb_pkg::result_t)
//
// one item at a time; busy stays high until its result strobe
// add: reciprocal multiply for the quotient, remainder, then check and store
// pop: one slot per cycle to find the head, one per cycle to find the next head, then the result states
// query or rejected header: only the timestamp read and result states
// reset clears occupancy, indexes and count at once; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module rtp_jitter_reorder_buffer_top #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rjb_pkg::item_t   item_i,
  output logic             valid_o,
  output rjb_pkg::result_t result_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned RW = IW + 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned HW = (HANDLE_BITS < rjb_pkg::HandleField) ?
                               HANDLE_BITS : rjb_pkg::HandleField;
  localparam int unsigned RecipShift = rjb_pkg::SeqBits + IW;
  localparam int unsigned Recip = ((1 << RecipShift) + SLOTS - 1) / SLOTS;
  localparam int unsigned PW = 2 * rjb_pkg::SeqBits + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_REM, S_CHK, S_SCAN, S_ADV, S_TRD_L, S_TRD_H, S_DONE
  } state_e;

  state_e           state_q;
  rjb_pkg::item_t   in_q;
  logic [SLOTS-1:0] full_q;
  logic [IW-1:0]    head_q, tail_q, scan_q, found_q, adv_q;
  logic [CW-1:0]    count_q;
  logic [RW-1:0]    rem_q;
  logic [rjb_pkg::SeqBits-1:0] quo_q;
  logic             acc_q, popv_q;
  logic [rjb_pkg::TimeBits-1:0] tl_q;
  logic             valid_q;
  rjb_pkg::result_t result_q;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = ({1'b0, i} == RW'(SLOTS - 1)) ? '0 : IW'({1'b0, i} + RW'(1));
  endfunction

  // slot index by reciprocal multiply
  logic [PW-1:0] quo_prod;
  logic [PW-1:0] quo_sh;
  logic [PW-1:0] rem_full;
  assign quo_prod = PW'(in_q.seq_number) * PW'(Recip);
  assign quo_sh = quo_prod >> RecipShift;
  assign rem_full = PW'(in_q.seq_number) - PW'(quo_q) * PW'(SLOTS);

  // add check
  logic [rjb_pkg::SeqBits-1:0]  seq_rd;
  logic [rjb_pkg::TimeBits-1:0] time_rd;
  logic [HW-1:0]                hdl_rd;
  logic [IW-1:0]  pos, last_idx, time_raddr;
  logic [RW-1:0]  span;
  logic [rjb_pkg::SeqBits-1:0] diff;
  logic signed [16:0] rel, lim;
  logic           empty, behind, ahead, store;

  assign pos = rem_q[IW-1:0];
  assign span = (tail_q >= head_q) ? RW'(tail_q) - RW'(head_q)
                                   : RW'(tail_q) + RW'(SLOTS) - RW'(head_q);
  assign diff = in_q.seq_number - seq_rd;
  assign rel = signed'({diff[15], diff});
  assign lim = signed'(17'(SLOTS - 1) - 17'(span));
  assign empty = (count_q == '0);
  assign behind = rel[16] && ((-rel) >= lim);
  assign ahead = rel > signed'(17'(SLOTS - 2));
  assign store = empty || !(behind || ahead);
  assign last_idx = (tail_q == '0) ? IW'(SLOTS - 1) : tail_q - IW'(1);
  assign time_raddr = (state_q == S_TRD_L) ? last_idx : head_q;

  logic we;
  assign we = (state_q == S_CHK) && store;

  rjb_ram #(.Width(rjb_pkg::SeqBits), .Depth(SLOTS)) u_seq_ram (
    .clk_i, .we_i(we), .waddr_i(pos), .wdata_i(in_q.seq_number),
    .raddr_i(head_q), .rdata_o(seq_rd)
  );

  rjb_ram #(.Width(rjb_pkg::TimeBits), .Depth(SLOTS)) u_time_ram (
    .clk_i, .we_i(we), .waddr_i(pos), .wdata_i(in_q.rtp_timestamp),
    .raddr_i(time_raddr), .rdata_o(time_rd)
  );

  rjb_ram #(.Width(HW), .Depth(SLOTS)) u_hdl_ram (
    .clk_i, .we_i(we), .waddr_i(pos), .wdata_i(in_q.packet_handle[HW-1:0]),
    .raddr_i(found_q), .rdata_o(hdl_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      full_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
      acc_q   <= 1'b0;
      popv_q  <= 1'b0;
      scan_q  <= '0;
      found_q <= '0;
      adv_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            in_q   <= item_i;
            acc_q  <= 1'b0;
            popv_q <= 1'b0;
            case (item_i.func)
              rjb_pkg::FuncAdd: begin
                if (item_i.header_ok) begin
                  state_q <= S_MOD;
                end else begin
                  state_q <= S_TRD_L;
                end
              end
              rjb_pkg::FuncPop: begin
                scan_q  <= head_q;
                state_q <= (count_q == '0) ? S_TRD_L : S_SCAN;
              end
              default: state_q <= S_TRD_L;
            endcase
          end
        end
        S_MOD: begin
          quo_q   <= quo_sh[rjb_pkg::SeqBits-1:0];
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q   <= rem_full[RW-1:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          acc_q <= store;
          if (store) begin
            full_q[pos] <= 1'b1;
            if (empty) begin
              head_q  <= pos;
              tail_q  <= nxt(pos);
              count_q <= CW'(1);
            end else begin
              if (!full_q[pos]) begin
                count_q <= count_q + CW'(1);
              end
              if (rel[16]) begin
                head_q <= pos;
              end else if (rel >= signed'(17'(span))) begin
                tail_q <= nxt(pos);
              end
            end
          end
          state_q <= S_TRD_L;
        end
        S_SCAN: begin
          if (scan_q == tail_q) begin
            state_q <= S_TRD_L;
          end else if (full_q[scan_q]) begin
            found_q <= scan_q;
            adv_q   <= nxt(head_q);
            state_q <= S_ADV;
          end else begin
            scan_q <= nxt(scan_q);
          end
        end
        S_ADV: begin
          if (full_q[adv_q] || adv_q == tail_q) begin
            head_q          <= adv_q;
            full_q[found_q] <= 1'b0;
            count_q         <= count_q - CW'(1);
            popv_q          <= 1'b1;
            state_q         <= S_TRD_L;
          end else begin
            adv_q <= nxt(adv_q);
          end
        end
        S_TRD_L: state_q <= S_TRD_H;
        S_TRD_H: begin
          tl_q    <= time_rd;
          state_q <= S_DONE;
        end
        S_DONE: begin
          result_q.accepted   <= acc_q;
          result_q.pop_valid  <= popv_q;
          result_q.packet_out <= popv_q ? rjb_pkg::HandleField'(hdl_rd) : '0;
          result_q.span_delay <= empty ? '0 : tl_q - time_rd;
          result_q.ref_delay  <= empty ? '0 : signed'(tl_q - in_q.ref_timestamp);
          result_q.fill_level <= rjb_pkg::FillBits'(count_q);
          result_q.is_empty   <= empty;
          valid_q             <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign result_o = result_q;

endmodule

/* rtl/core/rjb_ram.sv */
module rjb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
